// ----- hw/rtl/d2q9_bgk_collision_assert.svh -----
// Assertion macros used by the checker file.
`ifndef D2Q9_BGK_COLLISION_ASSERT_SVH
`define D2Q9_BGK_COLLISION_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and disabled during reset.
`define D2Q_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("d2q9 assertion failed");

// Next-cycle implication, sampled on i_clk and disabled during reset.
`define D2Q_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("d2q9 assertion failed");

`endif

// ----- hw/rtl/d2q_pkg.sv -----
`timescale 1ns / 1ps

package d2q_pkg;

    localparam int FRAC_BITS = 16;
    localparam int FIELD_W   = 18;
    localparam int OMEGA_W   = 17;
    localparam int NDIR      = 9;
    localparam int NSTG      = 9;
    localparam int USQ_W     = 37;

    localparam logic [OMEGA_W-1:0] RELAX_RESET = 17'd123653;

    // Reciprocal of 36 scaled by 2^35, rounded up; exact for dividends below 2^29.
    localparam logic [29:0] RECIP36    = 30'd954437177;
    localparam int          RECIP36_SH = 35;

    localparam logic signed [FIELD_W-1:0] FIELD_MAX = 18'sd131071;
    localparam logic signed [FIELD_W-1:0] FIELD_MIN = -18'sd131072;

    function automatic logic signed [1:0] dir_x(input logic [3:0] d);
        logic signed [1:0] r;
        case (d)
            4'd1, 4'd5, 4'd8: r = 2'sd1;
            4'd3, 4'd6, 4'd7: r = -2'sd1;
            default:          r = 2'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [1:0] dir_y(input logic [3:0] d);
        logic signed [1:0] r;
        case (d)
            4'd2, 4'd5, 4'd6: r = 2'sd1;
            4'd4, 4'd7, 4'd8: r = -2'sd1;
            default:          r = 2'sd0;
        endcase
        return r;
    endfunction

    // Weight in units of 1/36 is 16, 4 or 1, given as a left shift.
    function automatic logic [2:0] weight_shift(input logic [3:0] d);
        logic [2:0] r;
        case (d)
            4'd0:                   r = 3'd4;
            4'd1, 4'd2, 4'd3, 4'd4: r = 3'd2;
            default:                r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- hw/rtl/d2q9_bgk_collision.sv -----
`timescale 1ns / 1ps

// An accepted input transaction passes through the lane registers r1 to r9 to its output transaction.
// Throughput: one node per cycle while not stalled; the nine direction lanes run side by side.
// The whole pipeline holds while a finished output waits for i_ready.
// Reset (synchronous, active low) clears all valid bits and sets relax_rate to 123653.

module d2q9_bgk_collision (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [16:0]          i_cfg_wr_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [17:0]   i_dist_rest,
    input  logic signed [17:0]   i_dist_east,
    input  logic signed [17:0]   i_dist_north,
    input  logic signed [17:0]   i_dist_west,
    input  logic signed [17:0]   i_dist_south,
    input  logic signed [17:0]   i_dist_ne,
    input  logic signed [17:0]   i_dist_nw,
    input  logic signed [17:0]   i_dist_sw,
    input  logic signed [17:0]   i_dist_se,
    input  logic signed [17:0]   i_density,
    input  logic signed [17:0]   i_vel_x,
    input  logic signed [17:0]   i_vel_y,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [17:0]   o_post_rest,
    output logic signed [17:0]   o_post_east,
    output logic signed [17:0]   o_post_north,
    output logic signed [17:0]   o_post_west,
    output logic signed [17:0]   o_post_south,
    output logic signed [17:0]   o_post_ne,
    output logic signed [17:0]   o_post_nw,
    output logic signed [17:0]   o_post_sw,
    output logic signed [17:0]   o_post_se
);

    logic [d2q_pkg::OMEGA_W-1:0] r_relax_rate;
    logic [d2q_pkg::NSTG-1:0]    r_vld;
    logic signed [35:0]          r_sq_x;
    logic signed [35:0]          r_sq_y;
    logic [d2q_pkg::USQ_W-1:0]   r_usq;
    logic                        en;

    logic signed [17:0] w_f    [d2q_pkg::NDIR];
    logic signed [17:0] w_post [d2q_pkg::NDIR];

    assign en      = !r_vld[d2q_pkg::NSTG-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[d2q_pkg::NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relax_rate <= d2q_pkg::RELAX_RESET;
        end else if (i_cfg_wr_en) begin
            r_relax_rate <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[d2q_pkg::NSTG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_x <= i_vel_x * i_vel_x;
            r_sq_y <= i_vel_y * i_vel_y;
            r_usq  <= 37'(unsigned'(r_sq_x)) + 37'(unsigned'(r_sq_y));
        end
    end

    assign w_f[0] = i_dist_rest;
    assign w_f[1] = i_dist_east;
    assign w_f[2] = i_dist_north;
    assign w_f[3] = i_dist_west;
    assign w_f[4] = i_dist_south;
    assign w_f[5] = i_dist_ne;
    assign w_f[6] = i_dist_nw;
    assign w_f[7] = i_dist_sw;
    assign w_f[8] = i_dist_se;

    for (genvar k = 0; k < d2q_pkg::NDIR; k++) begin : g_lane
        d2q_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_dir   (4'(k)),
            .i_f     (w_f[k]),
            .i_rho   (i_density),
            .i_ux    (i_vel_x),
            .i_uy    (i_vel_y),
            .i_usq   (r_usq),
            .i_omega (r_relax_rate),
            .o_post  (w_post[k])
        );
    end

    assign o_post_rest  = w_post[0];
    assign o_post_east  = w_post[1];
    assign o_post_north = w_post[2];
    assign o_post_west  = w_post[3];
    assign o_post_south = w_post[4];
    assign o_post_ne    = w_post[5];
    assign o_post_nw    = w_post[6];
    assign o_post_sw    = w_post[7];
    assign o_post_se    = w_post[8];

endmodule

// ----- hw/rtl/d2q_lane.sv -----
`timescale 1ns / 1ps

module d2q_lane (
    input  logic                                      i_clk,
    input  logic                                      i_en,
    input  logic [3:0]                                i_dir,
    input  logic signed [d2q_pkg::FIELD_W-1:0]        i_f,
    input  logic signed [d2q_pkg::FIELD_W-1:0]        i_rho,
    input  logic signed [d2q_pkg::FIELD_W-1:0]        i_ux,
    input  logic signed [d2q_pkg::FIELD_W-1:0]        i_uy,
    input  logic [d2q_pkg::USQ_W-1:0]                 i_usq,
    input  logic [d2q_pkg::OMEGA_W-1:0]               i_omega,
    output logic signed [d2q_pkg::FIELD_W-1:0]        o_post
);

    logic signed [1:0]  ex;
    logic signed [1:0]  ey;
    logic signed [19:0] ux_x;
    logic signed [19:0] uy_x;
    logic signed [19:0] n1_eu;

    logic signed [19:0] r1_eu;
    logic signed [17:0] r1_f;
    logic signed [17:0] r1_rho;

    logic signed [39:0] r2_eu2;
    logic signed [19:0] r2_eu;
    logic signed [17:0] r2_f;
    logic signed [17:0] r2_rho;

    logic signed [43:0] eu_x;
    logic signed [43:0] eu2_x;
    logic signed [43:0] usq_x;
    logic signed [43:0] br2;
    logic [43:0]        br2_mag;
    logic [43:0]        br_sum;
    logic [26:0]        br_mag;
    logic signed [27:0] n3_br;

    logic signed [27:0] r3_br;
    logic signed [17:0] r3_f;
    logic signed [17:0] r3_rho;

    logic signed [45:0] r4_p;
    logic signed [17:0] r4_f;

    logic [45:0]        p_mag;
    logic [44:0]        y_sum;
    logic [2:0]         wsh;

    logic [28:0]        r5_y;
    logic               r5_neg;
    logic signed [17:0] r5_f;

    logic [58:0]        r6_prod;
    logic               r6_neg;
    logic signed [17:0] r6_f;

    logic [23:0]        q;
    logic signed [24:0] feq;
    logic signed [25:0] n7_diff;

    logic signed [25:0] r7_diff;
    logic signed [17:0] r7_f;

    logic signed [43:0] r8_prod;
    logic signed [17:0] r8_f;

    logic [43:0]        t_mag;
    logic [43:0]        t_sum;
    logic signed [28:0] term;
    logic signed [29:0] post_w;
    logic signed [17:0] n9_post;

    logic signed [17:0] r9_post;

    always_comb begin
        ex   = d2q_pkg::dir_x(i_dir);
        ey   = d2q_pkg::dir_y(i_dir);
        wsh  = d2q_pkg::weight_shift(i_dir);
        ux_x = 20'(i_ux);
        uy_x = 20'(i_uy);
        n1_eu = 20'sd0;
        if (ex == 2'sd1) begin
            n1_eu = n1_eu + ux_x;
        end else if (ex == -2'sd1) begin
            n1_eu = n1_eu - ux_x;
        end
        if (ey == 2'sd1) begin
            n1_eu = n1_eu + uy_x;
        end else if (ey == -2'sd1) begin
            n1_eu = n1_eu - uy_x;
        end
    end

    always_comb begin
        eu_x    = 44'(r2_eu);
        eu2_x   = 44'(r2_eu2);
        usq_x   = 44'(i_usq);
        br2     = (44'sd1 <<< 33) + 44'sd3 * (eu_x <<< 17) + 44'sd9 * eu2_x
                  - 44'sd3 * usq_x;
        br2_mag = br2[43] ? 44'(-br2) : 44'(br2);
        br_sum  = br2_mag + (44'd1 << 16);
        br_mag  = br_sum[43:17];
        n3_br   = br2[43] ? -$signed({1'b0, br_mag}) : $signed({1'b0, br_mag});
    end

    always_comb begin
        p_mag = r4_p[45] ? 46'(-r4_p) : 46'(r4_p);
        y_sum = (45'(p_mag) << wsh) + (45'd18 << 16);
    end

    always_comb begin
        q       = r6_prod[58:d2q_pkg::RECIP36_SH];
        feq     = r6_neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        n7_diff = 26'(r6_f) - 26'(feq);
    end

    always_comb begin
        t_mag  = r8_prod[43] ? 44'(-r8_prod) : 44'(r8_prod);
        t_sum  = t_mag + (44'd1 << 15);
        term   = r8_prod[43] ? -$signed({1'b0, t_sum[43:16]})
                             : $signed({1'b0, t_sum[43:16]});
        post_w = 30'(r8_f) - 30'(term);
        if (post_w > 30'(d2q_pkg::FIELD_MAX)) begin
            n9_post = d2q_pkg::FIELD_MAX;
        end else if (post_w < 30'(d2q_pkg::FIELD_MIN)) begin
            n9_post = d2q_pkg::FIELD_MIN;
        end else begin
            n9_post = post_w[17:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_eu   <= n1_eu;
            r1_f    <= i_f;
            r1_rho  <= i_rho;
            r2_eu2  <= r1_eu * r1_eu;
            r2_eu   <= r1_eu;
            r2_f    <= r1_f;
            r2_rho  <= r1_rho;
            r3_br   <= n3_br;
            r3_f    <= r2_f;
            r3_rho  <= r2_rho;
            r4_p    <= 46'(r3_rho) * 46'(r3_br);
            r4_f    <= r3_f;
            r5_y    <= y_sum[44:16];
            r5_neg  <= r4_p[45];
            r5_f    <= r4_f;
            r6_prod <= 59'(r5_y) * 59'(d2q_pkg::RECIP36);
            r6_neg  <= r5_neg;
            r6_f    <= r5_f;
            r7_diff <= n7_diff;
            r7_f    <= r6_f;
            r8_prod <= 44'($signed({1'b0, i_omega})) * 44'(r7_diff);
            r8_f    <= r7_f;
            r9_post <= n9_post;
        end
    end

    assign o_post = r9_post;

endmodule

// ----- hw/rtl/d2q_chk.sv -----
`timescale 1ns / 1ps
`include "d2q9_bgk_collision_assert.svh"

module d2q_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [17:0] o_post_rest,
    input logic signed [17:0] o_post_se
);

    `D2Q_ASSERT_IMP(a_ready_when_free, !o_valid || i_ready, o_ready)
    `D2Q_ASSERT_IMP(a_stall_only_when_full, !o_ready, o_valid && !i_ready)
    `D2Q_ASSERT_NXT(a_out_holds, o_valid && !i_ready, o_valid)
    `D2Q_ASSERT_NXT(a_out_stable, o_valid && !i_ready, $stable(o_post_rest) && $stable(o_post_se))

endmodule

bind d2q9_bgk_collision d2q_chk u_d2q_chk (.*);

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int LIMIT    = 400000;
    localparam int LATENCY  = 9;

    typedef logic signed [d2q_pkg::FIELD_W-1:0] t_fld;

    typedef struct {
        t_fld f[d2q_pkg::NDIR];
        t_fld rho;
        t_fld ux;
        t_fld uy;
    } t_node;

    typedef struct {
        t_fld p[d2q_pkg::NDIR];
    } t_post;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_en = 1'b0;
    logic [d2q_pkg::OMEGA_W-1:0] cfg_data = '0;
    logic in_vld = 1'b0;
    logic dut_rdy;
    t_fld in_f[d2q_pkg::NDIR];
    t_fld in_rho = '0;
    t_fld in_ux = '0;
    t_fld in_uy = '0;
    logic out_vld;
    logic out_rdy = 1'b0;
    t_fld out_p[d2q_pkg::NDIR];

    t_node node_q[$];
    t_post post_q[$];
    logic [d2q_pkg::OMEGA_W-1:0] omega_now = d2q_pkg::RELAX_RESET;
    int errors = 0;
    int nodes_sent = 0;
    int posts_seen = 0;
    int cycle = 0;

    initial begin
        for (int a = 0; a < d2q_pkg::NDIR; a++) begin
            in_f[a] = '0;
        end
    end

    d2q9_bgk_collision i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(cfg_en), .i_cfg_wr_data(cfg_data),
        .i_valid(in_vld), .o_ready(dut_rdy),
        .i_dist_rest(in_f[0]), .i_dist_east(in_f[1]), .i_dist_north(in_f[2]),
        .i_dist_west(in_f[3]), .i_dist_south(in_f[4]), .i_dist_ne(in_f[5]),
        .i_dist_nw(in_f[6]), .i_dist_sw(in_f[7]), .i_dist_se(in_f[8]),
        .i_density(in_rho), .i_vel_x(in_ux), .i_vel_y(in_uy),
        .o_valid(out_vld), .i_ready(out_rdy),
        .o_post_rest(out_p[0]), .o_post_east(out_p[1]), .o_post_north(out_p[2]),
        .o_post_west(out_p[3]), .o_post_south(out_p[4]), .o_post_ne(out_p[5]),
        .o_post_nw(out_p[6]), .o_post_sw(out_p[7]), .o_post_se(out_p[8])
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint round_div(longint n, longint d);
        longint mag;
        longint q;
        mag = (n < 0) ? -n : n;
        q = (mag + d / 2) / d;
        return (n < 0) ? -q : q;
    endfunction

    function automatic t_post collide(t_node n, logic [d2q_pkg::OMEGA_W-1:0] omega);
        t_post r;
        longint one_f;
        longint ux;
        longint uy;
        longint usq;
        longint eu;
        longint br;
        longint feq;
        longint term;
        longint v;
        longint wt;
        one_f = longint'(1) << d2q_pkg::FRAC_BITS;
        ux = n.ux;
        uy = n.uy;
        usq = ux * ux + uy * uy;
        for (int a = 0; a < d2q_pkg::NDIR; a++) begin
            eu = longint'(d2q_pkg::dir_x(4'(a))) * ux + longint'(d2q_pkg::dir_y(4'(a))) * uy;
            br = round_div(2 * one_f * one_f + 6 * eu * one_f + 9 * eu * eu - 3 * usq,
                           2 * one_f);
            wt = (a == 0) ? 16 : ((a < 5) ? 4 : 1);
            feq = round_div(wt * longint'(n.rho) * br, 36 * one_f);
            term = round_div(longint'(omega) * (longint'(n.f[a]) - feq),
                             longint'(1) << 16);
            v = longint'(n.f[a]) - term;
            if (v > 131071) v = 131071;
            if (v < -131072) v = -131072;
            r.p[a] = t_fld'(v);
        end
        return r;
    endfunction

    function automatic t_fld rnd_field();
        return t_fld'($urandom_range(0, 262143));
    endfunction

    function automatic t_node rnd_node();
        t_node n;
        if ($urandom_range(0, 99) < 60) begin
            // Physically plausible node: density near one, modest velocity.
            n.rho = t_fld'(65536 + $signed($urandom_range(0, 32768)) - 16384);
            n.ux = t_fld'($signed($urandom_range(0, 26000)) - 13000);
            n.uy = t_fld'($signed($urandom_range(0, 26000)) - 13000);
            for (int a = 0; a < d2q_pkg::NDIR; a++) begin
                n.f[a] = t_fld'($signed($urandom_range(0, 40000)) - 4000);
            end
        end else begin
            n.rho = rnd_field();
            n.ux = rnd_field();
            n.uy = rnd_field();
            for (int a = 0; a < d2q_pkg::NDIR; a++) begin
                n.f[a] = rnd_field();
            end
        end
        return n;
    endfunction

    function automatic t_node fill_node(t_fld f, t_fld rho, t_fld ux, t_fld uy);
        t_node n;
        for (int a = 0; a < d2q_pkg::NDIR; a++) begin
            n.f[a] = f;
        end
        n.rho = rho;
        n.ux = ux;
        n.uy = uy;
        return n;
    endfunction

    task automatic report_mismatch(string what, int lane, longint got, longint want);
        errors++;
        $display("mismatch at result %0d: %s lane %0d got %0d expected %0d",
                 posts_seen, what, lane, got, want);
    endtask

    function automatic logic quiet();
        return cycle > 2000 && cycle < 3500;
    endfunction

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > LIMIT) begin
            $display("timeout after %0d cycles", cycle);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_node n;
        if (!i_rst_n) begin
            in_vld <= 1'b0;
        end else begin
            if (in_vld && dut_rdy) begin
                n.rho = in_rho;
                n.ux = in_ux;
                n.uy = in_uy;
                for (int a = 0; a < d2q_pkg::NDIR; a++) begin
                    n.f[a] = in_f[a];
                end
                post_q.push_back(collide(n, omega_now));
                nodes_sent++;
            end
            if (!(in_vld && !dut_rdy)) begin
                if (node_q.size() > 0 && (quiet() || $urandom_range(0, 99) >= 17)) begin
                    n = node_q.pop_front();
                    in_vld <= 1'b1;
                    in_rho <= n.rho;
                    in_ux <= n.ux;
                    in_uy <= n.uy;
                    for (int a = 0; a < d2q_pkg::NDIR; a++) begin
                        in_f[a] <= n.f[a];
                    end
                end else begin
                    in_vld <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_post want;
        if (!i_rst_n) begin
            out_rdy <= 1'b0;
        end else begin
            if (out_vld && out_rdy) begin
                if (post_q.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0, 0);
                end else begin
                    want = post_q.pop_front();
                    for (int a = 0; a < d2q_pkg::NDIR; a++) begin
                        if (out_p[a] !== want.p[a]) begin
                            report_mismatch("post value", a, out_p[a], want.p[a]);
                        end
                    end
                end
                posts_seen++;
            end
            out_rdy <= quiet() || ($urandom_range(0, 99) >= 17);
        end
    end

    task automatic drain();
        while (node_q.size() > 0 || in_vld || post_q.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_omega(logic [d2q_pkg::OMEGA_W-1:0] v);
        @(posedge i_clk);
        cfg_en <= 1'b1;
        cfg_data <= v;
        omega_now = v;
        @(posedge i_clk);
        cfg_en <= 1'b0;
    endtask

    initial begin
        logic [d2q_pkg::OMEGA_W-1:0] rates[6];
        rates = '{d2q_pkg::RELAX_RESET, 17'd65536, 17'd0, 17'd131071, 17'd1, 17'd0};
        rates[5] = d2q_pkg::OMEGA_W'($urandom_range(0, 131071));
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        node_q.push_back(fill_node(t_fld'(0), t_fld'(0), t_fld'(0), t_fld'(0)));
        node_q.push_back(fill_node(d2q_pkg::FIELD_MAX, d2q_pkg::FIELD_MAX,
                                   d2q_pkg::FIELD_MAX, d2q_pkg::FIELD_MAX));
        node_q.push_back(fill_node(d2q_pkg::FIELD_MIN, d2q_pkg::FIELD_MIN,
                                   d2q_pkg::FIELD_MIN, d2q_pkg::FIELD_MIN));
        node_q.push_back(fill_node(d2q_pkg::FIELD_MAX, d2q_pkg::FIELD_MIN,
                                   d2q_pkg::FIELD_MAX, d2q_pkg::FIELD_MIN));
        node_q.push_back(fill_node(d2q_pkg::FIELD_MIN, d2q_pkg::FIELD_MAX,
                                   d2q_pkg::FIELD_MIN, d2q_pkg::FIELD_MAX));
        node_q.push_back(fill_node(t_fld'(7282), t_fld'(65536), t_fld'(0), t_fld'(0)));
        node_q.push_back(fill_node(t_fld'(7282), t_fld'(0), t_fld'(6553), t_fld'(-6553)));
        node_q.push_back(fill_node(t_fld'(-500), t_fld'(-65536), t_fld'(13107), t_fld'(0)));
        node_q.push_back(fill_node(t_fld'(1), t_fld'(65536), t_fld'(-1), t_fld'(1)));
        node_q.push_back(fill_node(t_fld'(0), t_fld'(65536), d2q_pkg::FIELD_MIN, t_fld'(0)));
        node_q.push_back(fill_node(t_fld'(0), d2q_pkg::FIELD_MAX, t_fld'(0),
                                   d2q_pkg::FIELD_MAX));

        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                write_omega(rates[ph]);
            end
            for (int k = 0; k < 225; k++) begin
                node_q.push_back(rnd_node());
            end
            drain();
        end

        if (post_q.size() != 0) begin
            report_mismatch("missing results", 0, post_q.size(), 0);
        end
        $display("Sent %0d nodes and checked %0d results over %0d cycles,", nodes_sent,
                 posts_seen, cycle);
        $display("across six relaxation rates including zero and the maximum.");
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/d2q_pkg.sv
hw/rtl/d2q_lane.sv
hw/rtl/d2q9_bgk_collision.sv
hw/rtl/d2q_chk.sv
bench/tb.sv
